// File: src/assert_macros.svh
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset
`define LSPE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition on one edge leads to another condition on the next edge
`define LSPE_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// File: src/lspe_pkg.sv
// Types and constants of the LED string pulse encoder
package lspe_pkg;

   localparam int CMD_W      = 2;
   localparam int IDX_W      = 3;
   localparam int WORD_W     = 32;
   localparam int BIT_W      = 5;
   localparam int TIME_W     = 10;
   localparam int GAP_W      = 18;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 40;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 18;

   // Command codes carried in tuser
   localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_COLOR = 2'd1;
   localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd2;

   // Register indices of the control port
   localparam logic [CSR_IDX_W-1:0] REG_ONE_HIGH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ONE_LOW   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ZERO_HIGH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ZERO_LOW  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_GAP       = 3'd4;

   localparam logic [TIME_W-1:0] ONE_HIGH_RST  = 10'd140;
   localparam logic [TIME_W-1:0] ONE_LOW_RST   = 10'd160;
   localparam logic [TIME_W-1:0] ZERO_HIGH_RST = 10'd70;
   localparam logic [TIME_W-1:0] ZERO_LOW_RST  = 10'd120;
   localparam logic [GAP_W-1:0]  GAP_RST       = 18'd200000;

   localparam logic [BIT_W-1:0]  MSB_BIT = 5'd31;

   typedef enum logic [2:0] {
      PH_GAP  = 3'b001,
      PH_BITS = 3'b010,
      PH_TAIL = 3'b100
   } phase_type;

   typedef struct packed {
      logic [TIME_W-1:0] one_high;
      logic [TIME_W-1:0] one_low;
      logic [TIME_W-1:0] zero_high;
      logic [TIME_W-1:0] zero_low;
      logic [GAP_W-1:0]  gap;
   } timing_type;

   typedef struct packed {
      logic              data_out;
      logic [WORD_W-1:0] countdown_now;
      logic              frame_done;
   } result_type;

   typedef struct packed {
      logic              in_bits;
      logic [WORD_W-1:0] countdown;
   } status_type;

endpackage

// File: src/lspe_csr.sv
// Timing registers of the LED string pulse encoder
module lspe_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [lspe_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lspe_pkg::CSR_DATA_W-1:0]   csr_wr_data,
   output lspe_pkg::timing_type              timing
);

   lspe_pkg::timing_type timing_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         timing_ff.one_high  <= lspe_pkg::ONE_HIGH_RST;
         timing_ff.one_low   <= lspe_pkg::ONE_LOW_RST;
         timing_ff.zero_high <= lspe_pkg::ZERO_HIGH_RST;
         timing_ff.zero_low  <= lspe_pkg::ZERO_LOW_RST;
         timing_ff.gap       <= lspe_pkg::GAP_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            lspe_pkg::REG_ONE_HIGH: begin
               timing_ff.one_high <= csr_wr_data[lspe_pkg::TIME_W-1:0];
            end
            lspe_pkg::REG_ONE_LOW: begin
               timing_ff.one_low <= csr_wr_data[lspe_pkg::TIME_W-1:0];
            end
            lspe_pkg::REG_ZERO_HIGH: begin
               timing_ff.zero_high <= csr_wr_data[lspe_pkg::TIME_W-1:0];
            end
            lspe_pkg::REG_ZERO_LOW: begin
               timing_ff.zero_low <= csr_wr_data[lspe_pkg::TIME_W-1:0];
            end
            lspe_pkg::REG_GAP: begin
               timing_ff.gap <= csr_wr_data[lspe_pkg::GAP_W-1:0];
            end
            default: begin
               // drop writes beyond the register list
            end
         endcase
      end
   end

   assign timing = timing_ff;

endmodule

// File: src/lspe_store.sv
// Colour word register file of the LED string pulse encoder
module lspe_store #(
   parameter int DEPTH = 8,
   parameter int AW    = 3
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [AW-1:0]                   wr_addr,
   input  logic [lspe_pkg::WORD_W-1:0]     wr_data,
   input  logic [AW-1:0]                   rd_addr,
   output logic [lspe_pkg::WORD_W-1:0]     rd_data
);

   logic [lspe_pkg::WORD_W-1:0] word_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         word_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = word_ff[rd_addr];

endmodule

// File: src/lspe_engine.sv
// Pulse timing engine: frame sequencing, bit slots and countdown
module lspe_engine #(
   parameter int LED_COUNT = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  logic [lspe_pkg::CMD_W-1:0]      cmd,
   input  logic [lspe_pkg::IDX_W-1:0]      led_index,
   input  logic [lspe_pkg::WORD_W-1:0]     color_value,
   input  logic [lspe_pkg::WORD_W-1:0]     countdown_value,
   input  lspe_pkg::timing_type            timing,
   output lspe_pkg::result_type            result,
   output lspe_pkg::status_type            status
);

   // Only eight LEDs can be addressed by a write, so the store never needs more
   localparam int STORE_DEPTH = (LED_COUNT < 8) ? LED_COUNT : 8;
   localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int LC_W        = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
   localparam logic [LC_W-1:0] LAST_LED = LC_W'(LED_COUNT - 1);

   lspe_pkg::phase_type          phase_ff, phase_in;
   logic [LC_W-1:0]              led_ff, led_in;
   logic [lspe_pkg::BIT_W-1:0]   bit_ff, bit_in;
   logic [lspe_pkg::GAP_W-1:0]   tick_ff, tick_in;
   logic                         low_half_ff, low_half_in;
   logic                         cur_bit_ff, cur_bit_in;
   logic [lspe_pkg::WORD_W-1:0]  countdown_ff, countdown_in;

   logic                         wr_en;
   logic [lspe_pkg::WORD_W-1:0]  rd_data;
   logic [lspe_pkg::WORD_W-1:0]  word;
   logic [lspe_pkg::WORD_W-1:0]  countdown_eff;
   logic [lspe_pkg::GAP_W-1:0]   tick_inc;
   logic [lspe_pkg::GAP_W-1:0]   gap_len;
   logic [lspe_pkg::TIME_W-1:0]  len_sel;
   logic [lspe_pkg::TIME_W-1:0]  len_eff;
   logic                         slot_start;
   logic                         bit_now;
   logic                         data_out;
   logic                         frame_done;

   assign wr_en = advance && (cmd == lspe_pkg::CMD_COLOR) && (32'(led_index) < STORE_DEPTH);

   lspe_store #(
      .DEPTH (STORE_DEPTH),
      .AW    (STORE_AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (led_index[STORE_AW-1:0]),
      .wr_data (color_value),
      .rd_addr (led_ff[STORE_AW-1:0]),
      .rd_data (rd_data)
   );

   // A colour written on the tick its slot begins is used for that bit
   assign word = (wr_en && (32'(led_index) == 32'(led_ff))) ? color_value : rd_data;

   always_comb begin
      countdown_eff = (cmd == lspe_pkg::CMD_LOAD) ? countdown_value : countdown_ff;
      tick_inc      = tick_ff + 1'b1;
      gap_len       = (timing.gap == '0) ? lspe_pkg::GAP_W'(1) : timing.gap;
      slot_start    = (tick_ff == '0) && !low_half_ff;
      bit_now       = slot_start ? word[bit_ff] : cur_bit_ff;
      if (low_half_ff) begin
         len_sel = bit_now ? timing.one_low : timing.zero_low;
      end else begin
         len_sel = bit_now ? timing.one_high : timing.zero_high;
      end
      len_eff = (len_sel == '0) ? lspe_pkg::TIME_W'(1) : len_sel;

      phase_in     = phase_ff;
      led_in       = led_ff;
      bit_in       = bit_ff;
      tick_in      = tick_ff;
      low_half_in  = low_half_ff;
      cur_bit_in   = cur_bit_ff;
      countdown_in = countdown_eff;
      data_out     = 1'b0;
      frame_done   = 1'b0;

      case (phase_ff)
         lspe_pkg::PH_GAP: begin
            tick_in = tick_inc;
            if (tick_inc >= gap_len) begin
               tick_in     = '0;
               phase_in    = lspe_pkg::PH_BITS;
               led_in      = '0;
               bit_in      = lspe_pkg::MSB_BIT;
               low_half_in = 1'b0;
               if (countdown_eff != '0) begin
                  countdown_in = countdown_eff - 1'b1;
               end
            end
         end
         lspe_pkg::PH_BITS: begin
            cur_bit_in = bit_now;
            data_out   = !low_half_ff;
            tick_in    = tick_inc;
            if (tick_inc >= lspe_pkg::GAP_W'(len_eff)) begin
               tick_in = '0;
               if (!low_half_ff) begin
                  low_half_in = 1'b1;
               end else begin
                  low_half_in = 1'b0;
                  if (bit_ff == '0) begin
                     bit_in = lspe_pkg::MSB_BIT;
                     if (led_ff == LAST_LED) begin
                        led_in     = '0;
                        frame_done = 1'b1;
                        phase_in   = lspe_pkg::PH_TAIL;
                     end else begin
                        led_in = led_ff + 1'b1;
                     end
                  end else begin
                     bit_in = bit_ff - 1'b1;
                  end
               end
            end
         end
         lspe_pkg::PH_TAIL: begin
            tick_in = tick_inc;
            if (tick_inc >= gap_len) begin
               tick_in  = '0;
               phase_in = lspe_pkg::PH_GAP;
            end
         end
         default: begin
            // restart the first gap
            phase_in = lspe_pkg::PH_GAP;
            tick_in  = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= lspe_pkg::PH_GAP;
         led_ff       <= '0;
         bit_ff       <= lspe_pkg::MSB_BIT;
         tick_ff      <= '0;
         low_half_ff  <= 1'b0;
         cur_bit_ff   <= 1'b0;
         countdown_ff <= '0;
      end else if (advance) begin
         phase_ff     <= phase_in;
         led_ff       <= led_in;
         bit_ff       <= bit_in;
         tick_ff      <= tick_in;
         low_half_ff  <= low_half_in;
         cur_bit_ff   <= cur_bit_in;
         countdown_ff <= countdown_in;
      end
   end

   assign result.data_out      = data_out;
   assign result.countdown_now = countdown_in;
   assign result.frame_done    = frame_done;
   assign status.in_bits       = (phase_ff == lspe_pkg::PH_BITS);
   assign status.countdown     = countdown_eff;

endmodule

// File: src/led_string_pulse_encoder_top.sv
// Path: an accepted transaction is held in the input register and its result is presented from the result register.
// Throughput: one transaction per cycle while the response side accepts results; each transaction is one tick
// of line timing, computed by the combinational timing engine between input and result registers.
// Reset: synchronous, active high; timing registers return to their defaults, the frame
// restarts in the first gap with a zero countdown. Colour words hold no value until written.
`include "assert_macros.svh"

module led_string_pulse_encoder_top #(
   parameter int LED_COUNT = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [2:0] led_index, [34:3] color_value, [66:35] countdown_value, [71:67] zero
   input  logic [lspe_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [1:0] cmd
   input  logic [lspe_pkg::CMD_W-1:0]         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [0] data_out, [32:1] countdown_now, [39:33] zero
   output logic [lspe_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // frame_done
   output logic                               rsp_tlast,
   input  logic                               csr_wr_en,
   input  logic [lspe_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lspe_pkg::CSR_DATA_W-1:0]    csr_wr_data
);

   logic                               in_valid_ff;
   logic [lspe_pkg::CMD_W-1:0]         cmd_ff;
   logic [lspe_pkg::IDX_W-1:0]         led_index_ff;
   logic [lspe_pkg::WORD_W-1:0]        color_ff;
   logic [lspe_pkg::WORD_W-1:0]        countdown_value_ff;

   logic                               rsp_valid_ff;
   logic                               rsp_data_ff;
   logic [lspe_pkg::WORD_W-1:0]        rsp_count_ff;
   logic                               rsp_last_ff;

   logic                               advance;
   logic                               req_accept;
   lspe_pkg::timing_type               timing;
   lspe_pkg::result_type               result;
   lspe_pkg::status_type               status;

   // Advance the engine whenever a transaction is held and the result register is free or being emptied
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff             <= req_tuser;
         led_index_ff       <= req_tdata[2:0];
         color_ff           <= req_tdata[34:3];
         countdown_value_ff <= req_tdata[66:35];
      end
   end

   lspe_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .timing      (timing)
   );

   lspe_engine #(
      .LED_COUNT (LED_COUNT)
   ) u_engine (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .cmd             (cmd_ff),
      .led_index       (led_index_ff),
      .color_value     (color_ff),
      .countdown_value (countdown_value_ff),
      .timing          (timing),
      .result          (result),
      .status          (status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff  <= result.data_out;
         rsp_count_ff <= result.countdown_now;
         rsp_last_ff  <= result.frame_done;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_count_ff, rsp_data_ff};
   assign rsp_tlast  = rsp_last_ff;

   // The last slot of a frame ends in its low half
   `LSPE_ASSERT(a_done_low, !(rsp_tvalid && rsp_tlast && rsp_tdata[0]), "frame end with line high")

   // A frame can only finish while bits are being sent
   `LSPE_ASSERT(a_done_in_bits, !(advance && result.frame_done && !status.in_bits), "frame end outside bit phase")

   // Without a load the countdown never rises
   `LSPE_ASSERT(a_count_no_rise, !(advance && result.countdown_now > status.countdown), "countdown rose")

   // An advanced transaction always lands in the result register
   `LSPE_ASSERT_NEXT(a_result_loaded, advance, rsp_tvalid, "result register not loaded")

endmodule
